### rtl/core/mfhd_pkg.sv
// Shared types and codes for the MQTT fixed-header deframer.
package mfhd_pkg;

   // Field widths of the byte stream and the decoded header.
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned LenWidth    = 28;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned MaxWidth    = 17;
   localparam int unsigned RoleWidth   = 2;
   localparam int unsigned ErrWidth    = 2;
   localparam int unsigned PhaseWidth  = 2;

   // Buffer size after reset.
   localparam logic [MaxWidth-1:0] MaxPacketReset = 17'd1024;

   // Framing phases.
   localparam logic [PhaseWidth-1:0] PhaseHeader = 2'd0;
   localparam logic [PhaseWidth-1:0] PhaseLength = 2'd1;
   localparam logic [PhaseWidth-1:0] PhaseBody   = 2'd2;
   localparam logic [PhaseWidth-1:0] PhaseHalt   = 2'd3;

   // Byte roles.
   localparam logic [RoleWidth-1:0] RoleHeader = 2'd0;
   localparam logic [RoleWidth-1:0] RoleLength = 2'd1;
   localparam logic [RoleWidth-1:0] RoleBody   = 2'd2;

   // Error codes.
   localparam logic [ErrWidth-1:0] ErrNone      = 2'd0;
   localparam logic [ErrWidth-1:0] ErrMalformed = 2'd1;
   localparam logic [ErrWidth-1:0] ErrTooLong   = 2'd2;

   // Length field bytes: continuation flag and data group.
   localparam int unsigned ContBit   = 7;
   localparam int unsigned GroupBits = 7;
   localparam logic [CountWidth-1:0] MaxLenBytes = 3'd4;

   // Framing state kept between bytes.
   typedef struct packed {
      logic [PhaseWidth-1:0]  phase;
      logic [NibbleWidth-1:0] pkt_type;
      logic [NibbleWidth-1:0] pkt_flags;
      logic [LenWidth-1:0]    len_acc;
      logic [CountWidth-1:0]  len_count;
      logic [LenWidth-1:0]    body_left;
      logic [ErrWidth-1:0]    err;
   } frame_state_type;

   // One tagged output byte.
   typedef struct packed {
      logic [ByteWidth-1:0]   byte_value;
      logic [RoleWidth-1:0]   byte_role;
      logic [NibbleWidth-1:0] packet_type;
      logic [NibbleWidth-1:0] packet_flags;
      logic [LenWidth-1:0]    remaining_length;
      logic [CountWidth-1:0]  length_field_bytes;
      logic                   last_of_packet;
      logic [ErrWidth-1:0]    error_code;
   } result_type;

endpackage

### rtl/core/mfhd_step.sv
// Combinational framing step: one byte against the current framing state.
module mfhd_step (
   input  mfhd_pkg::frame_state_type           cur_state,
   input  logic [mfhd_pkg::ByteWidth-1:0]      data_byte,
   input  logic [mfhd_pkg::MaxWidth-1:0]       max_packet_bytes,
   output mfhd_pkg::frame_state_type           next_state,
   output mfhd_pkg::result_type                result
);

   logic [mfhd_pkg::LenWidth-1:0]   group_shifted;
   logic [mfhd_pkg::LenWidth-1:0]   acc_sum;
   logic [mfhd_pkg::CountWidth-1:0] count_inc;
   logic [mfhd_pkg::LenWidth:0]     total_size;
   logic [mfhd_pkg::LenWidth-1:0]   left_dec;
   logic [mfhd_pkg::RoleWidth-1:0]  role;
   logic                            last;

   // Place the 7-bit group of this length byte at its position.
   always_comb begin
      group_shifted = '0;
      unique case (cur_state.len_count[1:0])
         2'd0: group_shifted = mfhd_pkg::LenWidth'(data_byte[6:0]);
         2'd1: group_shifted = mfhd_pkg::LenWidth'(data_byte[6:0]) << 7;
         2'd2: group_shifted = mfhd_pkg::LenWidth'(data_byte[6:0]) << 14;
         2'd3: group_shifted = mfhd_pkg::LenWidth'(data_byte[6:0]) << 21;
         default: group_shifted = '0;
      endcase
   end

   assign acc_sum    = cur_state.len_acc + group_shifted;
   assign count_inc  = cur_state.len_count + 3'd1;
   assign total_size = (mfhd_pkg::LenWidth+1)'(acc_sum)
                     + (mfhd_pkg::LenWidth+1)'(count_inc) + 29'd1;
   assign left_dec   = (cur_state.body_left != '0) ? cur_state.body_left - 28'd1
                                                   : cur_state.body_left;

   // Next framing state and this byte's role.
   always_comb begin
      next_state = cur_state;
      role       = mfhd_pkg::RoleHeader;
      last       = 1'b0;
      if (cur_state.err != mfhd_pkg::ErrNone) begin
         next_state.phase = mfhd_pkg::PhaseHalt;
      end else begin
         unique case (cur_state.phase)
            mfhd_pkg::PhaseHeader: begin
               role                 = mfhd_pkg::RoleHeader;
               next_state.pkt_type  = data_byte[7:4];
               next_state.pkt_flags = data_byte[3:0];
               next_state.len_acc   = '0;
               next_state.len_count = '0;
               next_state.body_left = '0;
               next_state.phase     = mfhd_pkg::PhaseLength;
            end
            mfhd_pkg::PhaseLength: begin
               role                 = mfhd_pkg::RoleLength;
               next_state.len_acc   = acc_sum;
               next_state.len_count = count_inc;
               if (data_byte[mfhd_pkg::ContBit]) begin
                  // A fourth byte that still continues is malformed.
                  if (count_inc >= mfhd_pkg::MaxLenBytes) begin
                     next_state.err   = mfhd_pkg::ErrMalformed;
                     next_state.phase = mfhd_pkg::PhaseHalt;
                  end
               end else if (total_size > (mfhd_pkg::LenWidth+1)'(max_packet_bytes)) begin
                  next_state.err   = mfhd_pkg::ErrTooLong;
                  next_state.phase = mfhd_pkg::PhaseHalt;
               end else if (acc_sum == '0) begin
                  // Packet with an empty body ends on its length byte.
                  last             = 1'b1;
                  next_state.phase = mfhd_pkg::PhaseHeader;
               end else begin
                  next_state.body_left = acc_sum;
                  next_state.phase     = mfhd_pkg::PhaseBody;
               end
            end
            mfhd_pkg::PhaseBody: begin
               role                 = mfhd_pkg::RoleBody;
               next_state.body_left = left_dec;
               if (left_dec == '0) begin
                  last             = 1'b1;
                  next_state.phase = mfhd_pkg::PhaseHeader;
               end
            end
            mfhd_pkg::PhaseHalt: begin
               next_state.phase = mfhd_pkg::PhaseHalt;
            end
            default: next_state.phase = mfhd_pkg::PhaseHalt;
         endcase
      end
   end

   // Tagged byte; once halted only the byte and the error are reported.
   always_comb begin
      result            = '0;
      result.byte_value = data_byte;
      result.error_code = cur_state.err;
      if (cur_state.err == mfhd_pkg::ErrNone && cur_state.phase != mfhd_pkg::PhaseHalt) begin
         result.byte_role          = role;
         result.packet_type        = next_state.pkt_type;
         result.packet_flags       = next_state.pkt_flags;
         result.remaining_length   = next_state.len_acc;
         result.length_field_bytes = next_state.len_count;
         result.last_of_packet     = last;
         result.error_code         = next_state.err;
      end
   end

endmodule

### rtl/core/mqtt_fixed_header_deframer.sv
// MQTT fixed-header deframer for one connection. Each request carries one
// received byte; the block answers each with one response that repeats the
// byte and tags it as header, remaining-length or body byte, together with
// the packet's type, flags, the remaining length decoded so far, the count of
// length bytes and a mark on the byte that completes the packet. A fourth
// length byte with its continuation bit set reports a malformed length, and a
// packet whose total size exceeds csr_wr_data as last written (1024 after
// reset) reports too long; either error holds until reset, and later bytes
// then pass through with only the error code. The block takes one byte every
// cycle unless responses stall: the decode is a single combinational step between
// the framing state and the response register, so a response appears the
// cycle after its request and a new request is taken while the response is
// being read. A new buffer size applies at the next end of a length field.
module mqtt_fixed_header_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mfhd_pkg::ByteWidth-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mfhd_pkg::ByteWidth-1:0]       rsp_byte_value,
   output logic [mfhd_pkg::RoleWidth-1:0]       rsp_byte_role,
   output logic [mfhd_pkg::NibbleWidth-1:0]     rsp_packet_type,
   output logic [mfhd_pkg::NibbleWidth-1:0]     rsp_packet_flags,
   output logic [mfhd_pkg::LenWidth-1:0]        rsp_remaining_length,
   output logic [mfhd_pkg::CountWidth-1:0]      rsp_length_field_bytes,
   output logic                                 rsp_last_of_packet,
   output logic [mfhd_pkg::ErrWidth-1:0]        rsp_error_code,
   input  logic                                 csr_wr_en,
   input  logic [mfhd_pkg::MaxWidth-1:0]        csr_wr_data
);

   mfhd_pkg::frame_state_type       state_ff, state_in;
   mfhd_pkg::result_type            result_ff, result_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mfhd_pkg::MaxWidth-1:0]   max_bytes_ff, max_bytes_in;
   logic                            req_accept;

   // Accept while the response register is empty or being drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   mfhd_step u_step (
      .cur_state        (state_ff),
      .data_byte        (req_data_byte),
      .max_packet_bytes (max_bytes_ff),
      .next_state       (state_in),
      .result           (result_in)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);
   assign max_bytes_in = csr_wr_en ? csr_wr_data : max_bytes_ff;

   // Control state and the buffer size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_bytes_ff <= mfhd_pkg::MaxPacketReset;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         max_bytes_ff <= max_bytes_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_byte_value         = result_ff.byte_value;
   assign rsp_byte_role          = result_ff.byte_role;
   assign rsp_packet_type        = result_ff.packet_type;
   assign rsp_packet_flags       = result_ff.packet_flags;
   assign rsp_remaining_length   = result_ff.remaining_length;
   assign rsp_length_field_bytes = result_ff.length_field_bytes;
   assign rsp_last_of_packet     = result_ff.last_of_packet;
   assign rsp_error_code         = result_ff.error_code;

endmodule

### rtl/core/mfhd_checker.sv
// Port-level checks for the deframer.
module mfhd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [mfhd_pkg::ByteWidth-1:0]       rsp_byte_value,
   input logic [mfhd_pkg::RoleWidth-1:0]       rsp_byte_role,
   input logic [mfhd_pkg::LenWidth-1:0]        rsp_remaining_length,
   input logic [mfhd_pkg::CountWidth-1:0]      rsp_length_field_bytes,
   input logic                                 rsp_last_of_packet,
   input logic [mfhd_pkg::ErrWidth-1:0]        rsp_error_code
);

   // A stalled response holds its byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value))
      else $error("stalled response changed");

   // Every accepted request yields a response in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // An error stays latched in every later response.
   a_err_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != mfhd_pkg::ErrNone
      |=> !rsp_valid || rsp_error_code == $past(rsp_error_code))
      else $error("error code dropped");

   // An erroring byte never completes a packet.
   a_err_no_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != mfhd_pkg::ErrNone |-> !rsp_last_of_packet)
      else $error("packet end marked with error");

   // A header byte starts with an empty length field.
   a_header_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == mfhd_pkg::ErrNone
      && rsp_byte_role == mfhd_pkg::RoleHeader
      |-> rsp_length_field_bytes == '0 && rsp_remaining_length == '0)
      else $error("header byte carries length data");

endmodule

bind mqtt_fixed_header_deframer mfhd_checker u_mfhd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_byte_value         (rsp_byte_value),
   .rsp_byte_role          (rsp_byte_role),
   .rsp_remaining_length   (rsp_remaining_length),
   .rsp_length_field_bytes (rsp_length_field_bytes),
   .rsp_last_of_packet     (rsp_last_of_packet),
   .rsp_error_code         (rsp_error_code)
);

### tb/mfhd_frame_checker.sv
`timescale 1ns / 100ps

module mfhd_frame_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [mfhd_pkg::ByteWidth-1:0]       req_data_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [mfhd_pkg::ByteWidth-1:0]       rsp_byte_value,
   input  logic [mfhd_pkg::RoleWidth-1:0]       rsp_byte_role,
   input  logic [mfhd_pkg::NibbleWidth-1:0]     rsp_packet_type,
   input  logic [mfhd_pkg::NibbleWidth-1:0]     rsp_packet_flags,
   input  logic [mfhd_pkg::LenWidth-1:0]        rsp_remaining_length,
   input  logic [mfhd_pkg::CountWidth-1:0]      rsp_length_field_bytes,
   input  logic                                 rsp_last_of_packet,
   input  logic [mfhd_pkg::ErrWidth-1:0]        rsp_error_code,
   input  logic                                 csr_wr_en,
   input  logic [mfhd_pkg::MaxWidth-1:0]        csr_wr_data,
   output int                                   outstanding,
   output int                                   fail_count
);

   import mfhd_pkg::*;

   // Framing state as the checker sees it, plus its copy of the buffer size.
   logic [PhaseWidth-1:0]  phase_q;
   logic [NibbleWidth-1:0] type_q;
   logic [NibbleWidth-1:0] flags_q;
   logic [LenWidth-1:0]    len_acc_q;
   logic [CountWidth-1:0]  len_count_q;
   logic [LenWidth-1:0]    body_left_q;
   logic [ErrWidth-1:0]    err_q;
   logic [MaxWidth-1:0]    max_bytes_q;

   // Tagged bytes still owed by the block, oldest first.
   result_type tagged_byte_q[$];

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   // Advance the framing state by one received byte and return its tagging.
   function automatic result_type tag_next_byte(input logic [ByteWidth-1:0] rx);
      result_type  t;
      logic [31:0] shifted;
      logic [31:0] total;
      t = '0;
      t.byte_value = rx;
      // Once an error is latched, bytes only pass through with the code.
      if (err_q != ErrNone || phase_q == PhaseHalt) begin
         t.error_code = err_q;
         return t;
      end
      case (phase_q)
         PhaseHeader: begin
            t.byte_role = RoleHeader;
            type_q      = rx[7:4];
            flags_q     = rx[3:0];
            len_acc_q   = '0;
            len_count_q = '0;
            body_left_q = '0;
            phase_q     = PhaseLength;
         end
         PhaseLength: begin
            t.byte_role = RoleLength;
            shifted     = 32'(rx[GroupBits-1:0]) << (GroupBits * len_count_q[1:0]);
            len_acc_q   = len_acc_q + shifted[LenWidth-1:0];
            len_count_q = len_count_q + 1'b1;
            if (rx[ContBit]) begin
               // A continuation on the fourth length byte is malformed.
               if (len_count_q >= MaxLenBytes) begin
                  err_q   = ErrMalformed;
                  phase_q = PhaseHalt;
               end
            end else begin
               total = 32'd1 + 32'(len_count_q) + 32'(len_acc_q);
               if (total > 32'(max_bytes_q)) begin
                  err_q   = ErrTooLong;
                  phase_q = PhaseHalt;
               end else if (len_acc_q == '0) begin
                  t.last_of_packet = 1'b1;
                  phase_q          = PhaseHeader;
               end else begin
                  body_left_q = len_acc_q;
                  phase_q     = PhaseBody;
               end
            end
         end
         default: begin
            // Body byte: count down to the end of the packet.
            t.byte_role = RoleBody;
            if (body_left_q != '0) begin
               body_left_q = body_left_q - 1'b1;
            end
            if (body_left_q == '0) begin
               t.last_of_packet = 1'b1;
               phase_q          = PhaseHeader;
            end
         end
      endcase
      t.packet_type        = type_q;
      t.packet_flags       = flags_q;
      t.remaining_length   = len_acc_q;
      t.length_field_bytes = len_count_q;
      t.error_code         = err_q;
      return t;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Watch both channels and the register port at every clock edge.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         phase_q     = PhaseHeader;
         type_q      = '0;
         flags_q     = '0;
         len_acc_q   = '0;
         len_count_q = '0;
         body_left_q = '0;
         err_q       = ErrNone;
         max_bytes_q = MaxPacketReset;
         tagged_byte_q.delete();
      end else begin
         if (csr_wr_en) begin
            max_bytes_q = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            tagged_byte_q.push_back(tag_next_byte(req_data_byte));
         end
         if (rsp_valid && rsp_ready) begin
            if (tagged_byte_q.size() == 0) begin
               $error("response with no request waiting: byte_value %0d", rsp_byte_value);
               fail_count++;
            end else begin
               want = tagged_byte_q.pop_front();
               compare_field("byte_value", want.byte_value, rsp_byte_value);
               compare_field("byte_role", want.byte_role, rsp_byte_role);
               compare_field("packet_type", want.packet_type, rsp_packet_type);
               compare_field("packet_flags", want.packet_flags, rsp_packet_flags);
               compare_field("remaining_length", want.remaining_length,
                             rsp_remaining_length);
               compare_field("length_field_bytes", want.length_field_bytes,
                             rsp_length_field_bytes);
               compare_field("last_of_packet", want.last_of_packet, rsp_last_of_packet);
               compare_field("error_code", want.error_code, rsp_error_code);
            end
         end
      end
      outstanding <= tagged_byte_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   import mfhd_pkg::*;

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [ByteWidth-1:0]   rsp_byte_value;
   logic [RoleWidth-1:0]   rsp_byte_role;
   logic [NibbleWidth-1:0] rsp_packet_type;
   logic [NibbleWidth-1:0] rsp_packet_flags;
   logic [LenWidth-1:0]    rsp_remaining_length;
   logic [CountWidth-1:0]  rsp_length_field_bytes;
   logic                   rsp_last_of_packet;
   logic [ErrWidth-1:0]    rsp_error_code;
   logic                   csr_wr_en     = 1'b0;
   logic [MaxWidth-1:0]    csr_wr_data   = '0;

   int outstanding;
   int check_failures;

   // Idle and stall rates in percent, set per phase.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // Rest of the packet being sent, its total size and the buffer size in force.
   logic [ByteWidth-1:0] pkt_bytes[$];
   int                   pkt_size = 0;
   int                   cur_max  = int'(MaxPacketReset);

   mqtt_fixed_header_deframer DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_byte_value         (rsp_byte_value),
      .rsp_byte_role          (rsp_byte_role),
      .rsp_packet_type        (rsp_packet_type),
      .rsp_packet_flags       (rsp_packet_flags),
      .rsp_remaining_length   (rsp_remaining_length),
      .rsp_length_field_bytes (rsp_length_field_bytes),
      .rsp_last_of_packet     (rsp_last_of_packet),
      .rsp_error_code         (rsp_error_code),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   mfhd_frame_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_byte_value         (rsp_byte_value),
      .rsp_byte_role          (rsp_byte_role),
      .rsp_packet_type        (rsp_packet_type),
      .rsp_packet_flags       (rsp_packet_flags),
      .rsp_remaining_length   (rsp_remaining_length),
      .rsp_length_field_bytes (rsp_length_field_bytes),
      .rsp_last_of_packet     (rsp_last_of_packet),
      .rsp_error_code         (rsp_error_code),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .outstanding            (outstanding),
      .fail_count             (check_failures)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Guard against a hung handshake.
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one byte, possibly after an idle gap, and wait for it to be taken.
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every tagged byte has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic send_list(ref logic [ByteWidth-1:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
      drain();
   endtask

   // Build a well-formed packet that fits the buffer size in force. The length
   // field is sometimes padded with zero groups up to four bytes.
   task automatic build_packet;
      int   body_len;
      int   n_min;
      int   n_len;
      int   sel;
      int   i;
      logic cont;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         body_len = $urandom_range(0, 15);
      end else if (sel < 95) begin
         body_len = $urandom_range(16, 200);
      end else begin
         body_len = $urandom_range(201, 600);
      end
      if (body_len > cur_max - 2) begin
         body_len = cur_max - 2;
      end
      forever begin
         n_min = 1;
         while ((body_len >> (GroupBits * n_min)) != 0) n_min++;
         if (1 + n_min + body_len <= cur_max) break;
         body_len--;
      end
      n_len = $urandom_range(n_min, 4);
      if (1 + n_len + body_len > cur_max) begin
         n_len = n_min;
      end
      pkt_bytes.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < n_len; i++) begin
         cont = (i < n_len - 1);
         pkt_bytes.push_back({cont, 7'((body_len >> (GroupBits * i)) & 'h7F)});
      end
      repeat (body_len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      pkt_size = 1 + n_len + body_len;
   endtask

   // Write the buffer size while the block is idle. A pending packet that
   // would not fit the new size is finished first.
   task automatic write_max(input int v);
      if (pkt_bytes.size() != 0 && pkt_size > v) begin
         while (pkt_bytes.size() != 0) send_byte(pkt_bytes.pop_front());
         drain();
      end
      csr_wr_en   <= 1'b1;
      csr_wr_data <= MaxWidth'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_max = v;
   endtask

   // Stream random packets; a phase may end in the middle of a packet.
   task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n_items) begin
         if (pkt_bytes.size() == 0) build_packet();
         send_byte(pkt_bytes.pop_front());
      end
      drain();
   endtask

   initial begin
      logic [ByteWidth-1:0] seq[$];
      int idle_tab[4];
      int stall_tab[4];
      int v;
      int p;
      idle_tab  = '{0, 56, 0, 33};
      stall_tab = '{0, 0, 56, 33};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default buffer size: empty packet with zero header, all-ones header with
      // a short body, a padded empty length, and a two-byte length with body.
      seq = '{8'h00, 8'h00, 8'hFF, 8'h03, 8'h00, 8'hFF, 8'h5A,
              8'h20, 8'h80, 8'h00, 8'h3B, 8'h81, 8'h00, 8'hC3};
      send_list(seq);

      // Four length bytes and a packet that fills the buffer exactly.
      write_max(10);
      seq = '{8'hA5, 8'h85, 8'h80, 8'h80, 8'h00, 8'h11, 8'h22, 8'h44, 8'h88, 8'h7E};
      send_list(seq);

      // Smallest buffer: only empty packets fit.
      write_max(2);
      seq = '{8'hD0, 8'h00, 8'hE1, 8'h00};
      send_list(seq);

      // Random packets over a range of buffer sizes and idle patterns.
      for (p = 0; p < 8; p++) begin
         case (p)
            0:       v = 'h1FFFF;
            1:       v = 65536;
            2:       v = $urandom_range(3, 300);
            3:       v = 1024;
            4:       v = 2;
            5:       v = $urandom_range(12, 2000);
            6:       v = $urandom_range(300, 65536);
            default: v = $urandom_range(20, 150);
         endcase
         write_max(v);
         run_phase(50, idle_tab[p % 4], stall_tab[p % 4]);
      end

      // Finish the open packet, then end on one of the two latched errors,
      // followed by bytes that must only pass through.
      req_idle_pct  = 33;
      rsp_stall_pct = 33;
      while (pkt_bytes.size() != 0) send_byte(pkt_bytes.pop_front());
      drain();
      seq.delete();
      if ($urandom_range(0, 1) == 0) begin
         // Malformed length: continuation still set on the fourth length byte.
         seq.push_back(8'($urandom_range(0, 255)));
         repeat (4) begin
            seq.push_back($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(128, 255)));
         end
      end else begin
         // Too long: the length field ends with a total above the buffer size.
         v = $urandom_range(0, 64);
         write_max(v);
         seq.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) begin
            seq.push_back(8'hFF);
            seq.push_back(8'hFF);
            seq.push_back(8'hFF);
            seq.push_back(8'h7F);
         end else begin
            seq.push_back(8'(v));
         end
      end
      repeat (20) seq.push_back(8'($urandom_range(0, 255)));
      send_list(seq);

      repeat (4) @(posedge clock);
      if (check_failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
